@@ src/bounded_deque_with_index_top_macros.svh @@
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_INDEX_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEX_TOP_MACROS_SVH

`ifndef SYNTHESIS

// checked at every edge outside reset
`define BDQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// types and constants shared by the bounded deque block
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = 6;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_READ_FRONT = 3'd4,
      ACT_READ_BACK  = 3'd5,
      ACT_READ_AT    = 3'd6,
      ACT_WRITE_AT   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_OOB   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

endpackage

@@ src/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_deque_with_index_top.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_index_top
// bounded double-ended queue of 32-bit values in a ring buffer ram
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   bdq_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   bdq_pkg::rsp_type
//
// one item per cycle while no result is stalled, one result per item. the ram
// read port and the pending stage register the item at the accepting edge, and
// the output register then loads the result from them.
// the ring ram is read or written at most once per item, at accept.
// reset clears head and count; the ram holds no reset state.
// a stalled result holds the pending stage, which then holds req_ready low.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_index_top_macros.svh"

module bounded_deque_with_index_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdq_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::rsp_type rsp_item
);

   import bdq_pkg::*;

   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int SUM_W = ((ADDR_W > CMP_W) ? ADDR_W : CMP_W) + 1;

   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [CMP_W-1:0]  pos);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(pos);
      if (s >= SUM_W'(CAPACITY)) begin
         s = s - SUM_W'(CAPACITY);
      end
      return s[ADDR_W-1:0];
   endfunction

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_valid_ff, pend_valid_in;
   status_type        pend_status_ff, pend_status_in;
   logic [CNT_W-1:0]  pend_count_ff, pend_count_in;
   logic              pend_rd_ff, pend_rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_accept;
   logic              load_out;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              is_full, is_empty, idx_ok;
   logic [ADDR_W-1:0] head_dec;
   status_type        status_c;
   logic              rd_c;

   assign load_out   = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !pend_valid_ff || load_out;
   assign req_accept = req_valid && req_ready;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign idx_ok   = (CMP_W'(req_item.index) < CMP_W'(count_ff));
   assign head_dec = (head_ff == '0) ? ADDR_W'(CAPACITY - 1) : head_ff - ADDR_W'(1);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      status_c = ST_OK;
      rd_c     = 1'b0;
      unique case (req_item.action)
         ACT_PUSH_FRONT: begin
            if (is_full) begin
               status_c = ST_FULL;
            end else begin
               head_in  = head_dec;
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_PUSH_BACK: begin
            if (is_full) begin
               status_c = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = slot_of(head_ff, CMP_W'(count_ff));
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (is_empty) begin
               status_c = ST_EMPTY;
            end else begin
               head_in  = slot_of(head_ff, CMP_W'(1));
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (is_empty) begin
               status_c = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_READ_FRONT: begin
            if (is_empty) begin
               status_c = ST_EMPTY;
            end else begin
               rd_en = 1'b1;
               rd_c  = 1'b1;
            end
         end
         ACT_READ_BACK: begin
            if (is_empty) begin
               status_c = ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_c    = 1'b1;
               rd_addr = slot_of(head_ff, CMP_W'(count_ff - CNT_W'(1)));
            end
         end
         ACT_READ_AT: begin
            if (!idx_ok) begin
               status_c = ST_OOB;
            end else begin
               rd_en   = 1'b1;
               rd_c    = 1'b1;
               rd_addr = slot_of(head_ff, CMP_W'(req_item.index));
            end
         end
         ACT_WRITE_AT: begin
            if (!idx_ok) begin
               status_c = ST_OOB;
            end else begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, CMP_W'(req_item.index));
            end
         end
         default: begin
            status_c = ST_OK;
         end
      endcase
      if (!req_accept) begin
         head_in  = head_ff;
         count_in = count_ff;
         wr_en    = 1'b0;
         rd_en    = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      pend_rd_in     = pend_rd_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_in.data   = pend_rd_ff ? rd_data : '0;
         rsp_in.status = pend_status_ff;
         rsp_in.count  = pend_count_ff;
         pend_valid_in = 1'b0;
      end
      if (req_accept) begin
         pend_valid_in  = 1'b1;
         pend_status_in = status_c;
         pend_count_in  = count_in;
         pend_rd_in     = rd_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      pend_rd_ff     <= pend_rd_in;
      rsp_ff         <= rsp_in;
   end

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BDQ_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `BDQ_ASSERT(a_head_bound,
      head_ff < ADDR_W'(CAPACITY - 1) || head_ff == ADDR_W'(CAPACITY - 1),
      "head outside ring")
   `BDQ_ASSERT(a_full_count,
      rsp_valid_ff && rsp_ff.status == ST_FULL |-> rsp_ff.count == CNT_W'(CAPACITY),
      "full reported below capacity")
   `BDQ_ASSERT(a_empty_count,
      rsp_valid_ff && rsp_ff.status == ST_EMPTY |-> rsp_ff.count == '0,
      "empty reported with elements")
   `BDQ_ASSERT(a_fail_data,
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.data == '0,
      "failed item carries data")
   `BDQ_ASSERT_ALWAYS(a_reset_clear,
      reset |=> count_ff == '0 && !rsp_valid_ff,
      "state not cleared by reset")

endmodule
